// ----- rtl/tcgb_pkg.sv -----
package tcgb_pkg;

	localparam logic [1:0] CMD_PRINT = 2'd0;
	localparam logic [1:0] CMD_SET_CURSOR = 2'd1;
	localparam logic [1:0] CMD_LOAD_FONT = 2'd2;

	localparam logic [1:0] FMT_565 = 2'd0;
	localparam logic [1:0] FMT_5551 = 2'd1;
	localparam logic [1:0] FMT_4444 = 2'd2;
	localparam logic [1:0] FMT_8888 = 2'd3;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_FG_COLOR = 3'd1;
	localparam logic [2:0] REG_BG_COLOR = 3'd2;
	localparam logic [2:0] REG_PIXEL_FORMAT = 3'd3;
	localparam logic [2:0] REG_LINE_STRIDE = 3'd4;
	localparam logic [2:0] REG_FRAME_BASE = 3'd5;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7E;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	localparam logic [7:0] ROW_MAX = 8'hFF;
	localparam logic [10:0] DEFAULT_STRIDE = 11'd512;
	localparam logic [5:0] PIX_LAST = 6'd63;

	localparam logic [31:0] FG_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] BG_RESET = 32'hFF1A_1A1A;

	typedef struct packed {
		logic [31:0] fg_color;
		logic [31:0] bg_color;
		logic [1:0] pixel_format;
		logic [10:0] line_stride;
		logic [23:0] frame_base;
	} cfg_t;

	typedef struct packed {
		logic set_cursor;
		logic font_wr;
		logic newline;
		logic start;
		logic mul;
		logic line;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_nl;
		logic out_free;
		logic pix_last;
	} ctl_sts_t;

	function automatic logic [31:0] to_format(input logic [31:0] w, input logic [1:0] fmt);
		logic [31:0] res;
		case (fmt)
			FMT_565: res = {16'd0, w[23:19], w[15:10], w[7:3]};
			FMT_5551: res = {16'd0, |w[31:24], w[23:19], w[15:11], w[7:3]};
			FMT_4444: res = {16'd0, w[31:28], w[23:20], w[15:12], w[7:4]};
			default: res = w;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/tcgb_ram.sv -----
module tcgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tcgb_ctrl.sv -----
module tcgb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_cmd,
	input  logic                enable,
	input  tcgb_pkg::ctl_sts_t  sts,
	output logic                in_ready,
	output tcgb_pkg::ctl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_LINE = 2'd2;
	localparam logic [1:0] ST_PIX = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						tcgb_pkg::CMD_SET_CURSOR: cmd.set_cursor = 1'b1;
						tcgb_pkg::CMD_LOAD_FONT: cmd.font_wr = 1'b1;
						tcgb_pkg::CMD_PRINT: begin
							if (enable) begin
								if (sts.is_nl) begin
									cmd.newline = 1'b1;
								end else begin
									cmd.start = 1'b1;
									state_d = ST_MUL;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LINE;
			end
			ST_LINE: begin
				cmd.line = 1'b1;
				state_d = ST_PIX;
			end
			ST_PIX: begin
				cmd.emit = sts.out_free;
				if (sts.out_free && sts.pix_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_start_reaches_pix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> ##2 (state_q == ST_PIX))
		else $error("print start did not reach pixel state");

	a_emit_only_in_pix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!in_ready && sts.out_free))
		else $error("pixel emitted outside pixel state");

endmodule

// ----- rtl/tcgb_dp.sv -----
module tcgb_dp #(
	parameter int GLYPH_COUNT = 256,
	parameter int TEXT_COLUMNS = 60,
	parameter int CELL_PITCH = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [39:0]         in_data,
	input  tcgb_pkg::cfg_t      cfg,
	input  tcgb_pkg::ctl_cmd_t  cmd,
	output tcgb_pkg::ctl_sts_t  sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         out_data,
	output logic                out_last
);

	localparam int GI_W = $clog2(GLYPH_COUNT);
	localparam int AW = GI_W + 3;
	localparam logic [6:0] COLS = 7'(TEXT_COLUMNS);

	logic [7:0] in_code;
	logic [5:0] in_col;
	logic [7:0] in_row;
	logic [2:0] in_grow;
	logic [7:0] in_gbits;
	logic [7:0] code_map;
	logic font_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_rdata;

	logic [5:0] cur_col_q;
	logic [7:0] cur_row_q;
	logic [GI_W-1:0] code_q;
	logic [2:0] rd_row_q;
	logic [5:0] k_q;
	logic [21:0] prod_q;
	logic [9:0] x0_q;
	logic [24:0] line_q;
	logic [7:0] bits_q;
	logic out_valid_q;
	logic [24:0] out_addr_q;
	logic [31:0] out_val_q;
	logic out_last_q;

	logic [10:0] stride;
	logic [10:0] y0;
	logic [31:0] fg_fmt;
	logic [31:0] bg_fmt;
	logic pix_bit;
	logic [6:0] col_inc;
	logic [7:0] row_inc;

	assign in_code = in_data[7:0];
	assign in_col = in_data[13:8];
	assign in_row = in_data[21:14];
	assign in_grow = in_data[24:22];
	assign in_gbits = in_data[32:25];

	assign code_map = (in_code < tcgb_pkg::CH_FIRST_PRINT || in_code > tcgb_pkg::CH_LAST_PRINT)
		? tcgb_pkg::CH_QMARK : in_code;

	assign font_we = cmd.font_wr && ({1'b0, in_code} < 9'(GLYPH_COUNT));
	assign ram_addr = cmd.font_wr ? {in_code[GI_W-1:0], in_grow} : {code_q, rd_row_q};

	tcgb_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_COUNT * 8)
	) u_font (
		.clk(clk),
		.we(font_we),
		.addr(ram_addr),
		.wdata(in_gbits),
		.rdata(ram_rdata)
	);

	assign stride = (cfg.line_stride == 11'd0) ? tcgb_pkg::DEFAULT_STRIDE : cfg.line_stride;
	assign y0 = {cur_row_q, 3'b000};
	assign fg_fmt = tcgb_pkg::to_format(cfg.fg_color, cfg.pixel_format);
	assign bg_fmt = tcgb_pkg::to_format(cfg.bg_color, cfg.pixel_format);
	assign pix_bit = (k_q[2:0] == 3'd0) ? ram_rdata[7] : bits_q[7];
	assign col_inc = {1'b0, cur_col_q} + 7'd1;
	assign row_inc = (cur_row_q < tcgb_pkg::ROW_MAX) ? cur_row_q + 8'd1 : cur_row_q;

	assign sts.is_nl = (in_code == tcgb_pkg::CH_LF) || (in_code == tcgb_pkg::CH_CR);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.pix_last = (k_q == tcgb_pkg::PIX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			rd_row_q <= '0;
		end else begin
			if (cmd.set_cursor) begin
				cur_col_q <= ({1'b0, in_col} >= COLS) ? 6'(COLS - 7'd1) : in_col;
				cur_row_q <= in_row;
			end else if (cmd.newline) begin
				cur_col_q <= '0;
				cur_row_q <= row_inc;
			end else if (cmd.line) begin
				if (col_inc >= COLS) begin
					cur_col_q <= '0;
					cur_row_q <= row_inc;
				end else begin
					cur_col_q <= col_inc[5:0];
				end
			end
			if (cmd.start) begin
				k_q <= '0;
				rd_row_q <= '0;
			end else if (cmd.emit) begin
				k_q <= k_q + 6'd1;
				if (k_q[2:0] == 3'd0) begin
					rd_row_q <= rd_row_q + 3'd1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			code_q <= code_map[GI_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= 22'(y0) * 22'(stride);
			x0_q <= 10'({4'd0, cur_col_q} * 10'(CELL_PITCH));
		end
		if (cmd.line) begin
			line_q <= 25'(cfg.frame_base) + 25'(prod_q) + 25'(x0_q);
		end else if (cmd.emit && k_q[2:0] == 3'd7) begin
			line_q <= line_q + 25'(stride);
		end
		if (cmd.emit) begin
			bits_q <= (k_q[2:0] == 3'd0) ? {ram_rdata[6:0], 1'b0} : {bits_q[6:0], 1'b0};
			out_addr_q <= line_q + 25'(k_q[2:0]);
			out_val_q <= pix_bit ? fg_fmt : bg_fmt;
			out_last_q <= (k_q == tcgb_pkg::PIX_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = {7'd0, out_val_q, out_addr_q};
	assign out_last = out_last_q;

	a_last_marks_final: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && k_q == tcgb_pkg::PIX_LAST) |=> (out_valid && out_last))
		else $error("final pixel not marked last");

	a_line_steps_stride: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && k_q[2:0] == 3'd7 && k_q != tcgb_pkg::PIX_LAST)
		|=> (line_q == $past(line_q) + 25'($past(stride))))
		else $error("line address did not advance by stride");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_col_q} < COLS))
		else $error("cursor column out of range");

endmodule

// ----- rtl/text_cell_glyph_blitter_top.sv -----
// Print: after the input transfer the states MUL and LINE run, then the first pixel enters
// the output register; then 64 pixel transfers at one per cycle while m_tready is high.
// The single font RAM port and the one-pixel output register set that rate.
// Set cursor, font load, CR/LF and disabled prints are handled in the idle state and do not leave it.
// arst_n clears the cursor, controller and output valid, and loads register reset values;
// the font store is not cleared and must be loaded before use.
module text_cell_glyph_blitter_top #(
	parameter int GLYPH_COUNT = 256,
	parameter int TEXT_COLUMNS = 60,
	parameter int CELL_PITCH = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // char_code, set_col, set_row, glyph_row, glyph_bits
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pixel_address, pixel_value
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic enable_q;
	tcgb_pkg::cfg_t cfg_q;
	tcgb_pkg::ctl_cmd_t cmd;
	tcgb_pkg::ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			cfg_q.fg_color <= tcgb_pkg::FG_RESET;
			cfg_q.bg_color <= tcgb_pkg::BG_RESET;
			cfg_q.pixel_format <= tcgb_pkg::FMT_8888;
			cfg_q.line_stride <= tcgb_pkg::DEFAULT_STRIDE;
			cfg_q.frame_base <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcgb_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				tcgb_pkg::REG_FG_COLOR: cfg_q.fg_color <= cfg_data;
				tcgb_pkg::REG_BG_COLOR: cfg_q.bg_color <= cfg_data;
				tcgb_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[1:0];
				tcgb_pkg::REG_LINE_STRIDE: cfg_q.line_stride <= cfg_data[10:0];
				tcgb_pkg::REG_FRAME_BASE: cfg_q.frame_base <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	tcgb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_cmd(s_tuser),
		.enable(enable_q),
		.sts(sts),
		.in_ready(s_tready),
		.cmd(cmd)
	);

	tcgb_dp #(
		.GLYPH_COUNT(GLYPH_COUNT),
		.TEXT_COLUMNS(TEXT_COLUMNS),
		.CELL_PITCH(CELL_PITCH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(s_tdata),
		.cfg(cfg_q),
		.cmd(cmd),
		.sts(sts),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata),
		.out_last(m_tlast)
	);

endmodule
